FILE: hdl/qpam_pkg.sv
// Shared types, constants and helper functions for the quadrotor PD attitude mixer.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package qpam_pkg;

  localparam int LANE_W     = 16;
  localparam int LANES_W    = 64;
  localparam int N_LANES    = 4;
  localparam int HOVER_W    = 31;
  localparam int FORCE_W    = 32;
  localparam int TORQUE_W   = 33;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;
  localparam int DB_W       = 15;
  localparam int TPS_W      = 16;
  localparam int GAIN_W     = 24;

  // datapath widths
  localparam int ALT_W      = 32;  // altitude target, Q7.24
  localparam int ALT_ERR_W  = 33;
  localparam int ERR_W      = 25;  // roll/pitch/yaw-rate errors, Q.14
  localparam int DIFF_W     = 17;  // yaw rate delta
  localparam int ACC_W      = 34;  // yaw acceleration estimate
  localparam int MA_W       = 35;  // multiplier operand A (signed)
  localparam int MB_W       = 25;  // multiplier operand B (unsigned gain, sign bit zero)
  localparam int PROD_W     = 60;
  localparam int FZ_W       = 56;  // PD efforts and mixer sums
  localparam int THR_W      = 28;
  localparam int THR_SCALE  = 1049;  // 0.001 in Q0.20
  localparam int THR_SHIFT  = 10;
  localparam int STEP_W     = 4;

  localparam logic [DB_W-1:0]   RST_DEADBAND = DB_W'(3277);
  localparam logic [TPS_W-1:0]  RST_TPS      = TPS_W'(1000);
  localparam logic [GAIN_W-1:0] RST_ALT_P    = GAIN_W'(655360);
  localparam logic [GAIN_W-1:0] RST_ALT_D    = GAIN_W'(327680);
  localparam logic [GAIN_W-1:0] RST_TILT_P   = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] RST_TILT_D   = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] RST_YAW_P    = GAIN_W'(655);
  localparam logic [GAIN_W-1:0] RST_YAW_D    = GAIN_W'(131);

  // mixer: bit k of row r set means effort k is subtracted for rotor r
  localparam logic [3:0][3:0] MIX_NEG = {4'b0010, 4'b1000, 4'b0100, 4'b1110};
  // rotors whose reaction torque is the negated force
  localparam logic [3:0] TORQUE_NEG = 4'b0101;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADBAND = 4'd0,
    REG_TPS      = 4'd1,
    REG_ALT_P    = 4'd2,
    REG_ALT_D    = 4'd3,
    REG_TILT_P   = 4'd4,
    REG_TILT_D   = 4'd5,
    REG_YAW_P    = 4'd6,
    REG_YAW_D    = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [DB_W-1:0]   deadband;
    logic [TPS_W-1:0]  tps;
    logic [GAIN_W-1:0] alt_p;
    logic [GAIN_W-1:0] alt_d;
    logic [GAIN_W-1:0] tilt_p;
    logic [GAIN_W-1:0] tilt_d;
    logic [GAIN_W-1:0] yaw_p;
    logic [GAIN_W-1:0] yaw_d;
  } cfg_t;

  // products issued to the shared multiplier, in issue order
  typedef enum logic [STEP_W-1:0] {
    OP_ACC     = 4'd0,
    OP_ALT_P   = 4'd1,
    OP_ALT_D   = 4'd2,
    OP_ROLL_P  = 4'd3,
    OP_ROLL_D  = 4'd4,
    OP_PITCH_P = 4'd5,
    OP_PITCH_D = 4'd6,
    OP_YAW_P   = 4'd7,
    OP_YAW_D   = 4'd8
  } mul_op_t;

  localparam logic [STEP_W-1:0] LAST_OP  = OP_YAW_D;
  localparam logic [STEP_W-1:0] LAST_MIX = STEP_W'(15);

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_8  = 2'd1,
    SH_14 = 2'd2,
    SH_24 = 2'd3
  } shift_t;

  typedef struct packed {
    logic       to_acc;
    logic [1:0] fz_idx;
    shift_t     shift;
  } route_t;

  typedef struct packed {
    logic       load_in;
    logic       prep1;
    logic       prep2;
    logic       mul_issue;
    mul_op_t    mul_op;
    logic       mix_en;
    logic [1:0] mix_rotor;
    logic [1:0] mix_k;
    logic       out_load;
  } ctrl_cmd_t;

  function automatic route_t op_route(mul_op_t op);
    route_t r;
    r = '{to_acc: 1'b0, fz_idx: 2'd0, shift: SH_8};
    unique case (op)
      OP_ACC:     r = '{to_acc: 1'b1, fz_idx: 2'd0, shift: SH_0};
      OP_ALT_P:   r = '{to_acc: 1'b0, fz_idx: 2'd0, shift: SH_24};
      OP_ALT_D:   r = '{to_acc: 1'b0, fz_idx: 2'd0, shift: SH_8};
      OP_ROLL_P:  r = '{to_acc: 1'b0, fz_idx: 2'd1, shift: SH_14};
      OP_ROLL_D:  r = '{to_acc: 1'b0, fz_idx: 2'd1, shift: SH_8};
      OP_PITCH_P: r = '{to_acc: 1'b0, fz_idx: 2'd2, shift: SH_14};
      OP_PITCH_D: r = '{to_acc: 1'b0, fz_idx: 2'd2, shift: SH_8};
      OP_YAW_P:   r = '{to_acc: 1'b0, fz_idx: 2'd3, shift: SH_14};
      OP_YAW_D:   r = '{to_acc: 1'b0, fz_idx: 2'd3, shift: SH_8};
      default:    r = '{to_acc: 1'b0, fz_idx: 2'd0, shift: SH_0};
    endcase
    return r;
  endfunction

  function automatic logic signed [FORCE_W-1:0] sat32(logic signed [FZ_W-1:0] x);
    logic [FZ_W-FORCE_W:0] hi;
    hi = x[FZ_W-1:FORCE_W-1];
    if ((&hi) || !(|hi)) begin
      return x[FORCE_W-1:0];
    end else if (x[FZ_W-1]) begin
      return {1'b1, {(FORCE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(FORCE_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/qpam_ifs.sv
// Valid/ready channel interfaces: input item, result item and register write port.
// Widths come from qpam_pkg.
`default_nettype none

interface qpam_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [qpam_pkg::LANES_W-1:0]           stick_lanes;
  logic [qpam_pkg::LANES_W-1:0]           attitude_lanes;
  logic [qpam_pkg::LANES_W-1:0]           rate_lanes;
  logic [qpam_pkg::LANES_W-1:0]           motion_lanes;
  logic [qpam_pkg::HOVER_W-1:0]           hover_thrust;
  logic                                   armed;

  modport source(output valid, stick_lanes, attitude_lanes, rate_lanes, motion_lanes,
                 hover_thrust, armed, input ready);
  modport sink(input valid, stick_lanes, attitude_lanes, rate_lanes, motion_lanes,
               hover_thrust, armed, output ready);
endinterface

interface qpam_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [qpam_pkg::FORCE_W-1:0]    force_rotor0;
  logic signed [qpam_pkg::FORCE_W-1:0]    force_rotor1;
  logic signed [qpam_pkg::FORCE_W-1:0]    force_rotor2;
  logic signed [qpam_pkg::FORCE_W-1:0]    force_rotor3;
  logic signed [qpam_pkg::TORQUE_W-1:0]   torque_rotor0;
  logic signed [qpam_pkg::FORCE_W-1:0]    torque_rotor1;
  logic signed [qpam_pkg::TORQUE_W-1:0]   torque_rotor2;
  logic signed [qpam_pkg::FORCE_W-1:0]    torque_rotor3;

  modport source(output valid, force_rotor0, force_rotor1, force_rotor2, force_rotor3,
                 torque_rotor0, torque_rotor1, torque_rotor2, torque_rotor3, input ready);
  modport sink(input valid, force_rotor0, force_rotor1, force_rotor2, force_rotor3,
               torque_rotor0, torque_rotor1, torque_rotor2, torque_rotor3, output ready);
endinterface

interface qpam_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [qpam_pkg::CFG_IDX_W-1:0]         reg_index;
  logic [qpam_pkg::CFG_DATA_W-1:0]        data;

  modport source(output valid, reg_index, data, input ready);
  modport sink(input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/qpam_cfg.sv
// Configuration register bank: deadband, tick rate and the six PD gains.
// Depends on qpam_pkg.
`default_nettype none

module qpam_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             wr_valid,
  output logic                                  wr_ready,
  input  wire logic [qpam_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire logic [qpam_pkg::CFG_DATA_W-1:0]  wr_data,
  output qpam_pkg::cfg_t                        cfg
);

  qpam_pkg::cfg_t cfg_r, cfg_nxt;

  assign wr_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_valid) begin
      unique case (qpam_pkg::cfg_reg_t'(wr_index))
        qpam_pkg::REG_DEADBAND: cfg_nxt.deadband = wr_data[qpam_pkg::DB_W-1:0];
        qpam_pkg::REG_TPS:      cfg_nxt.tps      = wr_data[qpam_pkg::TPS_W-1:0];
        qpam_pkg::REG_ALT_P:    cfg_nxt.alt_p    = wr_data[qpam_pkg::GAIN_W-1:0];
        qpam_pkg::REG_ALT_D:    cfg_nxt.alt_d    = wr_data[qpam_pkg::GAIN_W-1:0];
        qpam_pkg::REG_TILT_P:   cfg_nxt.tilt_p   = wr_data[qpam_pkg::GAIN_W-1:0];
        qpam_pkg::REG_TILT_D:   cfg_nxt.tilt_d   = wr_data[qpam_pkg::GAIN_W-1:0];
        qpam_pkg::REG_YAW_P:    cfg_nxt.yaw_p    = wr_data[qpam_pkg::GAIN_W-1:0];
        qpam_pkg::REG_YAW_D:    cfg_nxt.yaw_d    = wr_data[qpam_pkg::GAIN_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{deadband: qpam_pkg::RST_DEADBAND, tps: qpam_pkg::RST_TPS,
                 alt_p: qpam_pkg::RST_ALT_P, alt_d: qpam_pkg::RST_ALT_D,
                 tilt_p: qpam_pkg::RST_TILT_P, tilt_d: qpam_pkg::RST_TILT_D,
                 yaw_p: qpam_pkg::RST_YAW_P, yaw_d: qpam_pkg::RST_YAW_D};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/qpam_ctrl.sv
// Sequencer: input capture, error prep, multiply issue, mixer steps, output load.
// Depends on qpam_pkg; drives qpam_dp through ctrl_cmd_t.
`default_nettype none

module qpam_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output qpam_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP1 = 7'b0000010,
    S_PREP2 = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_MIX   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [qpam_pkg::STEP_W-1:0]     cnt_r, cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '{mul_op: qpam_pkg::OP_ACC, default: '0};
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_PREP1;
        end
      end
      S_PREP1: begin
        cmd.prep1 = 1'b1;
        state_nxt = S_PREP2;
      end
      S_PREP2: begin
        cmd.prep2 = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_issue = 1'b1;
        cmd.mul_op    = qpam_pkg::mul_op_t'(cnt_r);
        if (cnt_r == qpam_pkg::LAST_OP) begin
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        // last product lands in its effort register here
        cnt_nxt   = '0;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        cmd.mix_en    = 1'b1;
        cmd.mix_rotor = cnt_r[3:2];
        cmd.mix_k     = cnt_r[1:0];
        if (cnt_r == qpam_pkg::LAST_MIX) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/qpam_dp.sv
// Datapath: input registers, loop state, shared multiplier with rounding
// accumulator, serial mixer adder and output registers. Depends on qpam_pkg.
`default_nettype none

module qpam_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire qpam_pkg::ctrl_cmd_t                   cmd,
  input  wire qpam_pkg::cfg_t                        cfg,
  input  wire logic [qpam_pkg::LANES_W-1:0]          stick_lanes,
  input  wire logic [qpam_pkg::LANES_W-1:0]          attitude_lanes,
  input  wire logic [qpam_pkg::LANES_W-1:0]          rate_lanes,
  input  wire logic [qpam_pkg::LANES_W-1:0]          motion_lanes,
  input  wire logic [qpam_pkg::HOVER_W-1:0]          hover_thrust,
  input  wire logic                                  armed,
  output logic signed [qpam_pkg::FORCE_W-1:0]        force_o  [qpam_pkg::N_LANES],
  output logic signed [qpam_pkg::TORQUE_W-1:0]       torque_o [qpam_pkg::N_LANES]
);

  localparam int LW = qpam_pkg::LANE_W;
  localparam int NL = qpam_pkg::N_LANES;

  // captured item
  logic signed [LW-1:0]                    pos_r [NL];
  logic signed [LW-1:0]                    z_r   [NL];
  logic signed [LW-1:0]                    dz_r  [NL];
  logic signed [LW-1:0]                    mv_r  [NL];
  logic [qpam_pkg::HOVER_W-1:0]            hover_r;
  logic                                    armed_r;
  logic signed [LW-1:0]                    pos_nxt [NL];

  // loop state
  logic signed [qpam_pkg::ALT_W-1:0]       target_r, target_nxt;
  logic                                    loaded_r;
  logic signed [LW-1:0]                    last_r;

  // prepared errors
  logic signed [qpam_pkg::ERR_W-1:0]       er_r, ep_r, erate_r;
  logic signed [qpam_pkg::ERR_W-1:0]       er_nxt, ep_nxt, erate_nxt;
  logic signed [qpam_pkg::DIFF_W-1:0]      diff_r, diff_nxt;
  logic signed [qpam_pkg::ALT_ERR_W-1:0]   alt_err_r, alt_err_nxt;
  logic signed [qpam_pkg::ACC_W-1:0]       acc_r;

  // multiplier
  logic signed [qpam_pkg::MA_W-1:0]        ma;
  logic signed [qpam_pkg::MB_W-1:0]        mb;
  logic signed [qpam_pkg::PROD_W-1:0]      prod_r, prod_nxt, rnd;
  qpam_pkg::mul_op_t                       pop_r;
  logic                                    pvalid_r;
  qpam_pkg::route_t                        rt;
  logic signed [qpam_pkg::FZ_W-1:0]        term;

  // efforts and mixer
  logic signed [qpam_pkg::FZ_W-1:0]        fz_r [NL];
  logic signed [qpam_pkg::FZ_W-1:0]        racc_r, mbase, mterm, msum, fz_sel;
  logic signed [qpam_pkg::FORCE_W-1:0]     force_r [NL];

  // throttle integration
  logic signed [qpam_pkg::THR_W-1:0]       thr_prod, thr_inc;
  logic signed [qpam_pkg::ALT_W-1:0]       tbase, zsh;
  logic signed [qpam_pkg::ALT_ERR_W-1:0]   tdiff;

  // deadband on capture
  always_comb begin
    logic signed [LW-1:0] p;
    logic signed [LW:0]   pe;
    logic [LW:0]          mag;
    for (int i = 0; i < NL; i++) begin
      p   = stick_lanes[LW*i +: LW];
      pe  = (LW+1)'(p);
      mag = pe[LW] ? -pe : pe;
      pos_nxt[i] = (mag < (LW+1)'(cfg.deadband)) ? '0 : p;
    end
  end

  // altitude target and error terms
  always_comb begin
    zsh        = {z_r[0], 16'h0000};
    thr_prod   = qpam_pkg::THR_W'(pos_r[0]) * qpam_pkg::THR_W'(qpam_pkg::THR_SCALE);
    thr_inc    = (thr_prod + qpam_pkg::THR_W'(1 << (qpam_pkg::THR_SHIFT - 1)))
                 >>> qpam_pkg::THR_SHIFT;
    tbase      = loaded_r ? target_r : zsh;
    tdiff      = qpam_pkg::ALT_ERR_W'(tbase) - qpam_pkg::ALT_ERR_W'(thr_inc);
    target_nxt = qpam_pkg::sat32(qpam_pkg::FZ_W'(tdiff));
    alt_err_nxt = qpam_pkg::ALT_ERR_W'(target_r) - qpam_pkg::ALT_ERR_W'(zsh);

    // roll from y motion, pitch from x motion (negated), Q.14
    er_nxt = qpam_pkg::ERR_W'(pos_r[1])
           + (qpam_pkg::ERR_W'(mv_r[1]) <<< 6)
           + (qpam_pkg::ERR_W'(mv_r[3]) <<< 6)
           - (qpam_pkg::ERR_W'(z_r[1]) <<< 6);
    ep_nxt = -qpam_pkg::ERR_W'(pos_r[2])
           - (qpam_pkg::ERR_W'(mv_r[0]) <<< 6)
           - (qpam_pkg::ERR_W'(mv_r[2]) <<< 6)
           - (qpam_pkg::ERR_W'(z_r[2]) <<< 6);
    erate_nxt = -qpam_pkg::ERR_W'(pos_r[3]) - (qpam_pkg::ERR_W'(dz_r[3]) <<< 6);
    diff_nxt  = qpam_pkg::DIFF_W'(dz_r[3]) - qpam_pkg::DIFF_W'(last_r);
  end

  // operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.mul_op)
      qpam_pkg::OP_ACC: begin
        ma = qpam_pkg::MA_W'(diff_r);
        mb = qpam_pkg::MB_W'(cfg.tps);
      end
      qpam_pkg::OP_ALT_P: begin
        ma = qpam_pkg::MA_W'(alt_err_r);
        mb = qpam_pkg::MB_W'(cfg.alt_p);
      end
      qpam_pkg::OP_ALT_D: begin
        ma = -qpam_pkg::MA_W'(dz_r[0]);
        mb = qpam_pkg::MB_W'(cfg.alt_d);
      end
      qpam_pkg::OP_ROLL_P: begin
        ma = qpam_pkg::MA_W'(er_r);
        mb = qpam_pkg::MB_W'(cfg.tilt_p);
      end
      qpam_pkg::OP_ROLL_D: begin
        ma = -qpam_pkg::MA_W'(dz_r[1]);
        mb = qpam_pkg::MB_W'(cfg.tilt_d);
      end
      qpam_pkg::OP_PITCH_P: begin
        ma = qpam_pkg::MA_W'(ep_r);
        mb = qpam_pkg::MB_W'(cfg.tilt_p);
      end
      qpam_pkg::OP_PITCH_D: begin
        ma = -qpam_pkg::MA_W'(dz_r[2]);
        mb = qpam_pkg::MB_W'(cfg.tilt_d);
      end
      qpam_pkg::OP_YAW_P: begin
        ma = qpam_pkg::MA_W'(erate_r);
        mb = qpam_pkg::MB_W'(cfg.yaw_p);
      end
      qpam_pkg::OP_YAW_D: begin
        ma = -qpam_pkg::MA_W'(acc_r);
        mb = qpam_pkg::MB_W'(cfg.yaw_d);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod_nxt = ma * mb;
  end

  // round half up, then floor shift, on the registered product
  always_comb begin
    rt = qpam_pkg::op_route(pop_r);
    case (rt.shift)
      qpam_pkg::SH_8:  rnd = (prod_r + qpam_pkg::PROD_W'(1 << 7)) >>> 8;
      qpam_pkg::SH_14: rnd = (prod_r + qpam_pkg::PROD_W'(1 << 13)) >>> 14;
      qpam_pkg::SH_24: rnd = (prod_r + qpam_pkg::PROD_W'(1 << 23)) >>> 24;
      default:         rnd = prod_r;
    endcase
    term = rnd[qpam_pkg::FZ_W-1:0];
  end

  // mixer: one signed term per cycle, hover thrust seeds each rotor
  always_comb begin
    fz_sel = fz_r[cmd.mix_k];
    mterm  = qpam_pkg::MIX_NEG[cmd.mix_rotor][cmd.mix_k] ? -fz_sel : fz_sel;
    mbase  = (cmd.mix_k == 2'd0) ? qpam_pkg::FZ_W'({1'b0, hover_r}) : racc_r;
    msum   = mbase + mterm;
  end

  // loop state and control-side flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      loaded_r <= 1'b0;
      last_r   <= '0;
      pvalid_r <= 1'b0;
    end else begin
      pvalid_r <= cmd.mul_issue;
      if (cmd.prep1) begin
        target_r <= target_nxt;
        loaded_r <= 1'b1;
        last_r   <= dz_r[3];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    logic signed [qpam_pkg::FORCE_W-1:0] f;
    if (cmd.load_in) begin
      for (int i = 0; i < NL; i++) begin
        pos_r[i] <= pos_nxt[i];
        z_r[i]   <= attitude_lanes[LW*i +: LW];
        dz_r[i]  <= rate_lanes[LW*i +: LW];
        mv_r[i]  <= motion_lanes[LW*i +: LW];
      end
      hover_r <= hover_thrust;
      armed_r <= armed;
    end
    if (cmd.prep1) begin
      er_r    <= er_nxt;
      ep_r    <= ep_nxt;
      erate_r <= erate_nxt;
      diff_r  <= diff_nxt;
      for (int i = 0; i < NL; i++) begin
        fz_r[i] <= '0;
      end
    end
    if (cmd.prep2) begin
      alt_err_r <= alt_err_nxt;
    end
    if (cmd.mul_issue) begin
      prod_r <= prod_nxt;
      pop_r  <= cmd.mul_op;
    end
    if (pvalid_r) begin
      if (rt.to_acc) begin
        acc_r <= prod_r[qpam_pkg::ACC_W-1:0];
      end else begin
        for (int i = 0; i < NL; i++) begin
          if (rt.fz_idx == 2'(i)) begin
            fz_r[i] <= fz_r[i] + term;
          end
        end
      end
    end
    if (cmd.mix_en) begin
      racc_r <= msum;
      if (cmd.mix_k == 2'd3) begin
        for (int i = 0; i < NL; i++) begin
          if (cmd.mix_rotor == 2'(i)) begin
            force_r[i] <= qpam_pkg::sat32(msum);
          end
        end
      end
    end
    if (cmd.out_load) begin
      for (int i = 0; i < NL; i++) begin
        f = armed_r ? force_r[i] : '0;
        force_o[i]  <= f;
        torque_o[i] <= qpam_pkg::TORQUE_NEG[i] ? -qpam_pkg::TORQUE_W'(f)
                                               : qpam_pkg::TORQUE_W'(f);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/quadrotor_pd_attitude_mixer.sv
// Top level of the quadrotor PD attitude controller and motor mixer.
// Depends on qpam_pkg, qpam_ifs, qpam_cfg, qpam_ctrl and qpam_dp.
//
// One item is worked at a time; the next input is accepted once the result has
// been loaded into the output register, which waits while an older result is
// still unread. out_valid is set together with the result. The work is two prep
// steps, one shared 35x25 multiplier that takes the nine products (yaw
// acceleration and eight gain terms) in turn plus a drain step to land the last one,
// a single mixer adder that folds one effort per cycle into each of the four rotors,
// and one output load step. A finished result sits in the output
// register while the next item is accepted and worked on.
// Register writes are taken every cycle; write only while the block is idle.
`default_nettype none

module quadrotor_pd_attitude_mixer (
  input  wire logic   clk,
  input  wire logic   rst_n,
  qpam_in_if.sink     in_ch,
  qpam_out_if.source  out_ch,
  qpam_cfg_if.sink    cfg_ch
);

  qpam_pkg::cfg_t                              cfg;
  qpam_pkg::ctrl_cmd_t                         cmd;
  logic signed [qpam_pkg::FORCE_W-1:0]         force_o  [qpam_pkg::N_LANES];
  logic signed [qpam_pkg::TORQUE_W-1:0]        torque_o [qpam_pkg::N_LANES];

  qpam_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_ch.valid),
    .wr_ready (cfg_ch.ready),
    .wr_index (cfg_ch.reg_index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  qpam_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  qpam_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg            (cfg),
    .stick_lanes    (in_ch.stick_lanes),
    .attitude_lanes (in_ch.attitude_lanes),
    .rate_lanes     (in_ch.rate_lanes),
    .motion_lanes   (in_ch.motion_lanes),
    .hover_thrust   (in_ch.hover_thrust),
    .armed          (in_ch.armed),
    .force_o        (force_o),
    .torque_o       (torque_o)
  );

  assign out_ch.force_rotor0  = force_o[0];
  assign out_ch.force_rotor1  = force_o[1];
  assign out_ch.force_rotor2  = force_o[2];
  assign out_ch.force_rotor3  = force_o[3];
  assign out_ch.torque_rotor0 = torque_o[0];
  assign out_ch.torque_rotor1 = torque_o[1][qpam_pkg::FORCE_W-1:0];
  assign out_ch.torque_rotor2 = torque_o[2];
  assign out_ch.torque_rotor3 = torque_o[3][qpam_pkg::FORCE_W-1:0];

endmodule

`default_nettype wire

FILE: tb/sv/rotor_output_check.sv
// Watches the input, result and register-write channels of the attitude mixer,
// predicts each rotor result from the accepted control ticks and compares it.
// Depends on qpam_pkg (widths, register codes) and the channel interfaces in qpam_ifs.
module rotor_output_check
  import qpam_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  qpam_in_if        in_mon,
  qpam_out_if       out_mon,
  qpam_cfg_if       cfg_mon,
  output int        mismatches,
  output int        outstanding,
  output int        results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LANE_BITS     = 16;
  localparam int THROTTLE_STEP = 1049;  // 0.001 per tick in Q0.20
  localparam int THROTTLE_FRAC = 10;

  // effort order: altitude, roll, pitch, yaw
  localparam int ROTOR_MIX [4][4] = '{
    '{1, -1, -1, -1},
    '{1,  1, -1,  1},
    '{1,  1,  1, -1},
    '{1, -1,  1,  1}
  };

  typedef struct {
    logic [14:0] deadband;
    logic [15:0] tick_rate;
    logic [23:0] alt_p;
    logic [23:0] alt_d;
    logic [23:0] tilt_p;
    logic [23:0] tilt_d;
    logic [23:0] yaw_p;
    logic [23:0] yaw_d;
  } gain_set_t;

  typedef struct {
    logic signed [FORCE_W-1:0]  force_rotor0;
    logic signed [FORCE_W-1:0]  force_rotor1;
    logic signed [FORCE_W-1:0]  force_rotor2;
    logic signed [FORCE_W-1:0]  force_rotor3;
    logic signed [TORQUE_W-1:0] torque_rotor0;
    logic signed [FORCE_W-1:0]  torque_rotor1;
    logic signed [TORQUE_W-1:0] torque_rotor2;
    logic signed [FORCE_W-1:0]  torque_rotor3;
  } rotor_result_t;

  gain_set_t            gains;
  logic signed [31:0]   alt_target;   // Q7.24
  logic                 target_loaded;
  logic signed [15:0]   prev_yaw_rate;
  rotor_result_t        expected_rotors [$];
  int                   fail_count;
  int                   result_count;

  function automatic longint half_up(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_i32(longint x);
    if (x > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
    if (x < -longint'(32'sh7FFF_FFFF) - 1) return -longint'(32'sh7FFF_FFFF) - 1;
    return x;
  endfunction

  function automatic rotor_result_t predict_rotors(
    input logic [LANES_W-1:0] sticks, att, rates, motion,
    input logic [HOVER_W-1:0] hover,
    input logic               armed
  );
    longint        stick [4];
    longint        meas [4];
    longint        rate [4];
    longint        mov [4];
    longint        effort [4];
    longint        thrust [4];
    longint        mag, target, roll_err, pitch_err, yaw_err, yaw_acc;
    int            k, j;
    rotor_result_t r;
    for (k = 0; k < 4; k++) begin
      stick[k] = longint'($signed(sticks[LANE_BITS*k +: LANE_BITS]));
      mag = (stick[k] < 0) ? -stick[k] : stick[k];
      if (mag < longint'(gains.deadband)) stick[k] = 0;
      meas[k] = longint'($signed(att[LANE_BITS*k +: LANE_BITS]));
      rate[k] = longint'($signed(rates[LANE_BITS*k +: LANE_BITS]));
      mov[k]  = longint'($signed(motion[LANE_BITS*k +: LANE_BITS]));
    end

    // altitude reference seeds from the first measurement, then integrates throttle
    if (!target_loaded) begin
      target = meas[0] * 65536;
      target_loaded = 1'b1;
    end else begin
      target = longint'(alt_target);
    end
    target = clamp_i32(target - half_up(stick[0] * THROTTLE_STEP, THROTTLE_FRAC));
    alt_target = 32'(target);
    effort[0] = half_up((target - meas[0] * 65536) * longint'(gains.alt_p), 24) +
                half_up(-rate[0] * longint'(gains.alt_d), 8);

    // roll follows y motion, pitch follows x motion (negated), Q.14
    roll_err  = stick[1] + mov[1] * 64 + mov[3] * 64 - meas[1] * 64;
    pitch_err = -stick[2] - mov[0] * 64 - mov[2] * 64 - meas[2] * 64;
    effort[1] = half_up(roll_err * longint'(gains.tilt_p), 14) +
                half_up(-rate[1] * longint'(gains.tilt_d), 8);
    effort[2] = half_up(pitch_err * longint'(gains.tilt_p), 14) +
                half_up(-rate[2] * longint'(gains.tilt_d), 8);

    yaw_err   = -stick[3] - rate[3] * 64;
    yaw_acc   = (rate[3] - longint'(prev_yaw_rate)) * longint'(gains.tick_rate);
    effort[3] = half_up(yaw_err * longint'(gains.yaw_p), 14) +
                half_up(-yaw_acc * longint'(gains.yaw_d), 8);
    prev_yaw_rate = rates[4*LANE_BITS-1 -: LANE_BITS];

    for (k = 0; k < 4; k++) begin
      thrust[k] = 0;
      if (armed) begin
        thrust[k] = longint'(hover);
        for (j = 0; j < 4; j++) thrust[k] += ROTOR_MIX[k][j] * effort[j];
        thrust[k] = clamp_i32(thrust[k]);
      end
    end
    r.force_rotor0  = FORCE_W'(thrust[0]);
    r.force_rotor1  = FORCE_W'(thrust[1]);
    r.force_rotor2  = FORCE_W'(thrust[2]);
    r.force_rotor3  = FORCE_W'(thrust[3]);
    r.torque_rotor0 = TORQUE_W'(-thrust[0]);
    r.torque_rotor1 = FORCE_W'(thrust[1]);
    r.torque_rotor2 = TORQUE_W'(-thrust[2]);
    r.torque_rotor3 = FORCE_W'(thrust[3]);
    return r;
  endfunction

  task automatic compare_field(string field, logic signed [TORQUE_W-1:0] want,
                               logic signed [TORQUE_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    rotor_result_t want;
    if (!rst_n) begin
      gains         = '{deadband: 15'd3277, tick_rate: 16'd1000, alt_p: 24'd655360,
                        alt_d: 24'd327680, tilt_p: 24'd65536, tilt_d: 24'd65536,
                        yaw_p: 24'd655, yaw_d: 24'd131};
      alt_target    = '0;
      target_loaded = 1'b0;
      prev_yaw_rate = '0;
      expected_rotors.delete();
      fail_count    = 0;
      result_count  = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.reg_index)
          REG_DEADBAND: gains.deadband  = cfg_mon.data[14:0];
          REG_TPS:      gains.tick_rate = cfg_mon.data[15:0];
          REG_ALT_P:    gains.alt_p     = cfg_mon.data;
          REG_ALT_D:    gains.alt_d     = cfg_mon.data;
          REG_TILT_P:   gains.tilt_p    = cfg_mon.data;
          REG_TILT_D:   gains.tilt_d    = cfg_mon.data;
          REG_YAW_P:    gains.yaw_p     = cfg_mon.data;
          REG_YAW_D:    gains.yaw_d     = cfg_mon.data;
          default: ;  // spare indexes are dropped
        endcase
      end
      // retire before predicting so a result can never pair with a same-edge input
      if (out_mon.valid && out_mon.ready) begin
        result_count++;
        if (expected_rotors.size() == 0) begin
          $error("rotor result transfer with no prediction pending");
          fail_count++;
        end else begin
          want = expected_rotors.pop_front();
          compare_field("force_rotor0", want.force_rotor0, out_mon.force_rotor0);
          compare_field("force_rotor1", want.force_rotor1, out_mon.force_rotor1);
          compare_field("force_rotor2", want.force_rotor2, out_mon.force_rotor2);
          compare_field("force_rotor3", want.force_rotor3, out_mon.force_rotor3);
          compare_field("torque_rotor0", want.torque_rotor0, out_mon.torque_rotor0);
          compare_field("torque_rotor1", want.torque_rotor1, out_mon.torque_rotor1);
          compare_field("torque_rotor2", want.torque_rotor2, out_mon.torque_rotor2);
          compare_field("torque_rotor3", want.torque_rotor3, out_mon.torque_rotor3);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_rotors.push_back(predict_rotors(in_mon.stick_lanes, in_mon.attitude_lanes,
                                                 in_mon.rate_lanes, in_mon.motion_lanes,
                                                 in_mon.hover_thrust, in_mon.armed));
      end
    end
    mismatches   <= fail_count;
    outstanding  <= expected_rotors.size();
    results_seen <= result_count;
  end

endmodule

FILE: tb/sv/quadrotor_pd_attitude_mixer_test.sv
// Top of the attitude mixer testbench: clock, reset, control-tick and register
// stimulus, result back-pressure and the verdict. Depends on qpam_pkg, qpam_ifs,
// the block itself and rotor_output_check.
module quadrotor_pd_attitude_mixer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import qpam_pkg::*;

  localparam int LANE_BITS    = 16;
  localparam int RANDOM_TICKS = 600;
  localparam int PHASES       = 6;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_LO = CFG_IDX_W'(REG_YAW_D) + 1'b1;
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_HI = '1;
  localparam logic [LANE_BITS-1:0] LANE_MAX = 16'h7FFF;
  localparam logic [LANE_BITS-1:0] LANE_MIN = 16'h8000;
  localparam logic [CFG_DATA_W-1:0] GAIN_MAX = '1;

  logic clk;
  logic rst_n;
  qpam_in_if  in_ch();
  qpam_out_if out_ch();
  qpam_cfg_if cfg_ch();

  int   mismatches;
  int   outstanding;
  int   results_seen;
  bit   steady;
  int   stall_left;
  int   ticks_sent;
  int   reg_writes;
  int   settings_used;
  logic [14:0]        cur_deadband;
  logic [LANES_W-1:0] last_att, last_rate, last_motion;

  quadrotor_pd_attitude_mixer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rotor_output_check rotor_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_mon      (cfg_ch),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("timeout: results still pending = %0d", outstanding);
    $display("status: fail");
    $finish;
  end

  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (steady) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) < 65);
      stall_left   <= idle_cycles();
    end
  end

  function automatic logic [LANES_W-1:0] pack_lanes(logic [LANE_BITS-1:0] l0, l1, l2, l3);
    return {l3, l2, l1, l0};
  endfunction

  function automatic logic [LANE_BITS-1:0] stick_value();
    int roll;
    logic [LANE_BITS-1:0] v;
    roll = $urandom_range(0, 99);
    if (roll < 30) v = LANE_BITS'(cur_deadband) + LANE_BITS'($urandom_range(0, 4)) - 16'd2;
    else if (roll < 70) v = LANE_BITS'($urandom_range(0, 16384));
    else if (roll < 88) v = LANE_BITS'($urandom);
    else if (roll < 94) v = LANE_MAX;
    else v = LANE_MIN;
    if (roll < 70 && $urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  function automatic logic [LANE_BITS-1:0] measured_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return LANE_BITS'(int'($urandom_range(0, 2048)) - 1024);
    if (roll < 75) return LANE_BITS'(int'($urandom_range(0, 16384)) - 8192);
    if (roll < 90) return LANE_BITS'($urandom);
    if (roll < 95) return LANE_MAX;
    return LANE_MIN;
  endfunction

  function automatic logic [LANES_W-1:0] fresh_lanes();
    return pack_lanes(measured_value(), measured_value(), measured_value(), measured_value());
  endfunction

  // small step from the previous tick, the way a flying vehicle moves
  function automatic logic [LANES_W-1:0] drift_lanes(logic [LANES_W-1:0] prev);
    logic [LANES_W-1:0] v;
    int k;
    for (k = 0; k < 4; k++)
      v[LANE_BITS*k +: LANE_BITS] = prev[LANE_BITS*k +: LANE_BITS] +
                                    LANE_BITS'(int'($urandom_range(0, 128)) - 64);
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return CFG_DATA_W'($urandom_range(0, 1 << 18));
    if (roll < 60) return CFG_DATA_W'($urandom);
    if (roll < 70) return '0;
    if (roll < 80) return GAIN_MAX;
    return CFG_DATA_W'($urandom_range(0, 1 << 20));
  endfunction

  task automatic send_tick(logic [LANES_W-1:0] sticks, att, rates, motion,
                           logic [HOVER_W-1:0] hover, logic armed);
    int gap;
    in_ch.valid          <= 1'b1;
    in_ch.stick_lanes    <= sticks;
    in_ch.attitude_lanes <= att;
    in_ch.rate_lanes     <= rates;
    in_ch.motion_lanes   <= motion;
    in_ch.hover_thrust   <= hover;
    in_ch.armed          <= armed;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ticks_sent++;
    last_att    = att;
    last_rate   = rates;
    last_motion = motion;
    gap = steady ? 0 : idle_cycles();
    // valid stays high into the next call when there is no gap
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_tick();
    logic [LANES_W-1:0] att, rates, motion;
    logic [HOVER_W-1:0] hover;
    int roll;
    if ($urandom_range(0, 99) < 70) begin
      att    = drift_lanes(last_att);
      rates  = drift_lanes(last_rate);
      motion = drift_lanes(last_motion);
    end else begin
      att    = fresh_lanes();
      rates  = fresh_lanes();
      motion = fresh_lanes();
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) hover = HOVER_W'($urandom_range(0, 1 << 20));
    else if (roll < 85) hover = HOVER_W'($urandom);
    else if (roll < 92) hover = '0;
    else hover = '1;
    send_tick(pack_lanes(stick_value(), stick_value(), stick_value(), stick_value()),
              att, rates, motion, hover, $urandom_range(0, 99) < 85);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data      <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    reg_writes++;
    if (idx == REG_DEADBAND) cur_deadband = value[14:0];
  endtask

  task automatic write_settings(logic [CFG_DATA_W-1:0] deadband, tick_rate, alt_p, alt_d,
                                tilt_p, tilt_d, yaw_p, yaw_d, bit spare);
    write_reg(REG_DEADBAND, deadband);
    write_reg(REG_TPS, tick_rate);
    write_reg(REG_ALT_P, alt_p);
    write_reg(REG_ALT_D, alt_d);
    write_reg(REG_TILT_P, tilt_p);
    write_reg(REG_TILT_D, tilt_d);
    write_reg(REG_YAW_P, yaw_p);
    write_reg(REG_YAW_D, yaw_d);
    if (spare) begin
      write_reg(SPARE_REG_LO, CFG_DATA_W'($urandom));
      write_reg(SPARE_REG_HI, CFG_DATA_W'($urandom));
    end
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // hold the sender until every predicted result has been taken
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int p, k;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.stick_lanes    <= '0;
    in_ch.attitude_lanes <= '0;
    in_ch.rate_lanes     <= '0;
    in_ch.motion_lanes   <= '0;
    in_ch.hover_thrust   <= '0;
    in_ch.armed          <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.reg_index     <= '0;
    cfg_ch.data          <= '0;
    steady        = 1'b0;
    ticks_sent    = 0;
    reg_writes    = 0;
    settings_used = 1;
    cur_deadband  = 15'd3277;
    last_att      = '0;
    last_rate     = '0;
    last_motion   = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // power-on gains: first tick seeds the altitude reference near the top of
    // its range with throttle at -2.0 (no clip yet), and has yaw rate with no history
    send_tick(pack_lanes(LANE_MIN, 16'h0000, 16'h0000, 16'h0000),
              pack_lanes(LANE_MAX, 16'h0100, 16'hFF00, 16'h0000),
              pack_lanes(16'h0080, 16'h0040, 16'hFFC0, 16'h0300),
              pack_lanes(16'h0020, 16'hFFE0, 16'h0010, 16'h0008), HOVER_W'(32'h0004_E000), 1'b1);
    send_tick(pack_lanes(LANE_MIN, 16'h1000, 16'hF000, 16'h2000),
              pack_lanes(LANE_MAX, 16'h0100, 16'hFF00, 16'h0000),
              pack_lanes(16'h0080, 16'h0040, 16'hFFC0, 16'h0300),
              pack_lanes(16'h0020, 16'hFFE0, 16'h0010, 16'h0008), HOVER_W'(32'h0004_E000), 1'b0);
    send_tick({4{LANE_MAX}}, {4{LANE_MAX}}, {4{LANE_MAX}}, {4{LANE_MAX}}, '1, 1'b1);
    send_tick({4{LANE_MIN}}, {4{LANE_MIN}}, {4{LANE_MIN}}, {4{LANE_MIN}}, '0, 1'b1);
    send_tick('0, '0, '0, '0, HOVER_W'(32'h0001_0000), 1'b1);
    // sticks either side of the deadband
    send_tick(pack_lanes(16'd3277, 16'(-3277), 16'd3276, 16'(-3276)),
              pack_lanes(16'h0200, 16'h0010, 16'hFFF0, 16'h0040),
              pack_lanes(16'h0000, 16'h0008, 16'hFFF8, 16'h0100),
              pack_lanes(16'h0004, 16'hFFFC, 16'h0002, 16'hFFFE), HOVER_W'(32'h0004_E000), 1'b1);
    send_tick({4{16'h5555}}, {4{16'hAAAA}}, {4{16'h5555}}, {4{16'hAAAA}},
              HOVER_W'(32'h2AAA_AAAA), 1'b1);
    send_tick({4{16'hAAAA}}, {4{16'h5555}}, {4{16'hAAAA}}, {4{16'h5555}},
              HOVER_W'(32'h5555_5555), 1'b1);

    // no deadband, no tick rate (yaw acceleration drops out), every gain at full scale
    drain();
    write_settings('0, '0, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, 1'b0);
    send_tick({4{LANE_MIN}}, {4{LANE_MAX}}, {4{LANE_MIN}}, {4{LANE_MAX}}, '1, 1'b1);
    send_tick({4{LANE_MAX}}, {4{LANE_MIN}}, {4{LANE_MAX}}, {4{LANE_MIN}}, '0, 1'b1);
    random_tick();

    // widest legal deadband, fastest tick rate, all gains off
    drain();
    write_settings(CFG_DATA_W'(16384), CFG_DATA_W'(16'hFFFF), '0, '0, '0, '0, '0, '0, 1'b0);
    send_tick(pack_lanes(LANE_MIN, 16'h4000, 16'h3FFF, 16'(-16384)), fresh_lanes(),
              pack_lanes(16'h0100, 16'h0200, 16'h0300, LANE_MIN), fresh_lanes(),
              HOVER_W'(32'h0010_0000), 1'b1);
    random_tick();

    // deadband from overwide data, unit gains, spare register indexes
    drain();
    write_settings(GAIN_MAX, CFG_DATA_W'(1), CFG_DATA_W'(1), CFG_DATA_W'(1), CFG_DATA_W'(1),
                   CFG_DATA_W'(1), CFG_DATA_W'(1), CFG_DATA_W'(1), 1'b1);
    send_tick(pack_lanes(LANE_MIN, LANE_MAX, 16'h8001, 16'h7FFE), fresh_lanes(),
              pack_lanes(16'h0100, 16'h0200, 16'h0300, LANE_MAX), fresh_lanes(), '1, 1'b1);
    random_tick();

    for (p = 0; p < PHASES; p++) begin
      drain();
      if (p == 0) begin
        write_settings(CFG_DATA_W'(3277), CFG_DATA_W'(1000), CFG_DATA_W'(655360),
                       CFG_DATA_W'(327680), CFG_DATA_W'(65536), CFG_DATA_W'(65536),
                       CFG_DATA_W'(655), CFG_DATA_W'(131), 1'b0);
      end else begin
        write_settings(($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) :
                                                      CFG_DATA_W'($urandom_range(0, 16384)),
                       ($urandom_range(0, 9) < 2) ? CFG_DATA_W'($urandom_range(0, 1)) :
                       ($urandom_range(0, 9) == 0) ? CFG_DATA_W'(16'hFFFF) :
                                                     CFG_DATA_W'($urandom_range(50, 4000)),
                       pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                       pick_gain(), $urandom_range(0, 2) == 0);
      end
      steady <= (p == 1);
      for (k = 0; k < RANDOM_TICKS / PHASES; k++) random_tick();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d control ticks over %0d gain settings, %0d register writes",
             ticks_sent, settings_used, reg_writes);
    $display("%0d rotor results compared field by field, %0d field mismatches",
             results_seen, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
